/* rtl/mf3_pkg.sv */
// Shared types, constants and compare helpers for the 3x3 median filter.
package mf3_pkg;

  localparam int unsigned MaxDim   = 256;
  localparam int unsigned AddrW    = $clog2(MaxDim);
  localparam int unsigned DimW     = AddrW + 1;
  localparam int unsigned PixW     = 8;
  localparam int unsigned WinSize  = 9;
  localparam int unsigned WinSide  = 3;

  // Register indexes on the configuration port
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // Three values in ascending order
  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } trip_t;

  // Per-item tags that travel alongside the data path
  typedef struct packed {
    pix_t             px;
    logic [AddrW-1:0] row;
    logic [AddrW-1:0] col;
    logic             has_med;
    logic             border;
    logic             last;
  } meta_t;

  function automatic trip_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t  x0, x1, x2, t;
    trip_t s;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    s.lo  = x0;
    s.mid = x1;
    s.hi  = x2;
    return s;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    trip_t s;
    s = sort3(a, b, c);
    return s.mid;
  endfunction

endpackage

/* rtl/mf3_line_mem.sv */
// Line store RAM: one entry per column holding the two rows above.
module mf3_line_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [mf3_pkg::AddrW-1:0]   waddr_i,
  input  logic [2*mf3_pkg::PixW-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [mf3_pkg::AddrW-1:0]   raddr_i,
  output logic [2*mf3_pkg::PixW-1:0]  rdata_o
);

  logic [2*mf3_pkg::PixW-1:0] mem_q [mf3_pkg::MaxDim];
  logic [2*mf3_pkg::PixW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mf3_median.sv */
// Two-stage median-of-nine network: sort rows, then pick three candidates.
module mf3_median (
  input  logic                                  clk_i,
  input  logic                                  load_sort_i,
  input  logic                                  load_cand_i,
  input  mf3_pkg::pix_t [mf3_pkg::WinSize-1:0]  win_i,
  output mf3_pkg::pix_t                         med_o
);

  mf3_pkg::trip_t [mf3_pkg::WinSide-1:0] sort_d, sort_q;
  mf3_pkg::pix_t  lo_max_q, mid_med_q, hi_min_q;

  // Sort each window row
  always_comb begin
    for (int k = 0; k < mf3_pkg::WinSide; k++) begin
      sort_d[k] = mf3_pkg::sort3(win_i[k*mf3_pkg::WinSide],
                                 win_i[k*mf3_pkg::WinSide+1],
                                 win_i[k*mf3_pkg::WinSide+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sort_i) begin
      sort_q <= sort_d;
    end
  end

  // Largest low, middle of mids, smallest high
  always_ff @(posedge clk_i) begin
    if (load_cand_i) begin
      lo_max_q  <= mf3_pkg::max3(sort_q[0].lo, sort_q[1].lo, sort_q[2].lo);
      mid_med_q <= mf3_pkg::med3(sort_q[0].mid, sort_q[1].mid, sort_q[2].mid);
      hi_min_q  <= mf3_pkg::min3(sort_q[0].hi, sort_q[1].hi, sort_q[2].hi);
    end
  end

  assign med_o = mf3_pkg::med3(lo_max_q, mid_med_q, hi_min_q);

endmodule

/* rtl/median_filter_3x3_core.sv */
// Top level of the streaming 3x3 median filter with line stores and output buffer.
//
//  Channel   Direction  Contents
//  s_*       in         one pixel per item, raster order
//  m_*       out        median or passed border pixel with coordinates
//  APB       in/out     image_width at 0x0, image_height at 0x4
//
// One pixel is accepted per cycle unless an output stall holds the stages. A pixel
// is registered in stage 1, window, row sort, candidates and an output item buffer;
// it drains one result per cycle with m_tready; a median-and-border pixel holds it.
// The line store RAM is read when a pixel is taken and written one stage later,
// with forwarding when consecutive pixels hit the same column.
// Reset clears counters, window and valid flags; the line store needs no sweep.
// Stalls on the output back up stage by stage; empty stages keep filling.
module median_filter_3x3_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_tdata: [7:0] pixel_in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // m_tdata: [7:0] out_row, [15:8] out_col, [23:16] out_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  // m_tuser: [0] is_median, [1] frame_end
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = mf3_pkg::AddrW;
  localparam int unsigned DimW  = mf3_pkg::DimW;
  localparam int unsigned PixW  = mf3_pkg::PixW;

  // ---------------- configuration ----------------
  logic [DimW-1:0] width_q, height_q;
  logic            cfg_wr;
  logic            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(mf3_pkg::MaxDim);
      height_q <= DimW'(mf3_pkg::MaxDim);
    end else if (cfg_wr) begin
      if (cfg_idx == mf3_pkg::RegWidth) begin
        width_q <= pwdata[DimW-1:0];
      end else begin
        height_q <= pwdata[DimW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == mf3_pkg::RegWidth) begin
      prdata[DimW-1:0] = width_q;
    end else begin
      prdata[DimW-1:0] = height_q;
    end
  end

  // Clamp dimensions to 1..MaxDim
  logic [DimW-1:0] w_eff, h_eff;
  always_comb begin
    priority if (width_q == '0) w_eff = DimW'(1);
    else if (width_q > DimW'(mf3_pkg::MaxDim)) w_eff = DimW'(mf3_pkg::MaxDim);
    else w_eff = width_q;
    priority if (height_q == '0) h_eff = DimW'(1);
    else if (height_q > DimW'(mf3_pkg::MaxDim)) h_eff = DimW'(mf3_pkg::MaxDim);
    else h_eff = height_q;
  end

  // ---------------- stage handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;
  logic free1, free2, free3, free4, ob_free;
  logic ob_med_v_q, ob_bor_v_q;

  assign ob_free = (!ob_med_v_q && !ob_bor_v_q) || (m_tready && (ob_med_v_q ^ ob_bor_v_q));
  assign adv4    = v4_q && ob_free;
  assign free4   = !v4_q || adv4;
  assign adv3    = v3_q && free4;
  assign free3   = !v3_q || adv3;
  assign adv2    = v2_q && free3;
  assign free2   = !v2_q || adv2;
  assign adv1    = v1_q && free2;
  assign free1   = !v1_q || adv1;

  assign s_tready = free1;

  logic accept;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (free1) v1_q <= accept;
      if (free2) v2_q <= adv1;
      if (free3) v3_q <= adv2;
      if (free4) v4_q <= adv3;
    end
  end

  // ---------------- position counters ----------------
  logic [AddrW-1:0] row_q, col_q;
  logic             col_wrap, row_wrap;

  assign col_wrap = ({1'b0, col_q} + DimW'(1)) >= w_eff;
  assign row_wrap = ({1'b0, row_q} + DimW'(1)) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + AddrW'(1);
      end else begin
        col_q <= col_q + AddrW'(1);
      end
    end
  end

  // Tag the item at acceptance
  mf3_pkg::meta_t meta_d;
  always_comb begin
    meta_d.px      = s_tdata;
    meta_d.row     = row_q;
    meta_d.col     = col_q;
    meta_d.has_med = (row_q >= AddrW'(2)) && (col_q >= AddrW'(2));
    meta_d.border  = (({2'b0, row_q} + (DimW+1)'(2)) >= {1'b0, h_eff}) ||
                     (({2'b0, col_q} + (DimW+1)'(2)) >= {1'b0, w_eff});
    meta_d.last    = row_wrap && col_wrap;
  end

  mf3_pkg::meta_t m1_q, m2_q, m3_q, m4_q;

  always_ff @(posedge clk_i) begin
    if (accept) m1_q <= meta_d;
    if (adv1)   m2_q <= m1_q;
    if (adv2)   m3_q <= m2_q;
    if (adv3)   m4_q <= m3_q;
  end

  // ---------------- line store read-modify-write ----------------
  logic [2*PixW-1:0] mem_rdata, mem_wdata, line_eff;
  logic [2*PixW-1:0] fwd_data_q;
  logic              fwd_q;
  logic              fwd_hit;
  mf3_pkg::pix_t     up_eff, mid_eff;

  assign line_eff  = fwd_q ? fwd_data_q : mem_rdata;
  assign up_eff    = line_eff[2*PixW-1:PixW];
  assign mid_eff   = line_eff[PixW-1:0];
  // Shift the column up: middle moves to upper, new pixel into middle
  assign mem_wdata = {mid_eff, m1_q.px};
  assign fwd_hit   = adv1 && (m1_q.col == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= fwd_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && fwd_hit) fwd_data_q <= mem_wdata;
  end

  mf3_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (m1_q.col),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  // ---------------- window ----------------
  mf3_pkg::pix_t [mf3_pkg::WinSize-1:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv1) begin
      for (int k = 0; k < mf3_pkg::WinSide; k++) begin
        win_q[k*mf3_pkg::WinSide]   <= win_q[k*mf3_pkg::WinSide+1];
        win_q[k*mf3_pkg::WinSide+1] <= win_q[k*mf3_pkg::WinSide+2];
      end
      win_q[2] <= up_eff;
      win_q[5] <= mid_eff;
      win_q[8] <= m1_q.px;
    end
  end

  // ---------------- median network ----------------
  mf3_pkg::pix_t med;

  mf3_median u_median (
    .clk_i       (clk_i),
    .load_sort_i (adv2),
    .load_cand_i (adv3),
    .win_i       (win_q),
    .med_o       (med)
  );

  // ---------------- output item buffer ----------------
  mf3_pkg::pix_t    ob_med_val_q, ob_px_q;
  logic [AddrW-1:0] ob_row_q, ob_col_q;
  logic             ob_run_end_q, ob_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_med_v_q <= 1'b0;
      ob_bor_v_q <= 1'b0;
    end else if (adv4) begin
      ob_med_v_q <= m4_q.has_med;
      ob_bor_v_q <= m4_q.border;
    end else if (m_tready) begin
      // Drop the result just taken: median goes first
      if (ob_med_v_q) ob_med_v_q <= 1'b0;
      else            ob_bor_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      ob_med_val_q <= med;
      ob_px_q      <= m4_q.px;
      ob_row_q     <= m4_q.row;
      ob_col_q     <= m4_q.col;
      ob_run_end_q <= !m4_q.border;
      ob_last_q    <= m4_q.last;
    end
  end

  assign m_tvalid = ob_med_v_q || ob_bor_v_q;

  always_comb begin
    if (ob_med_v_q) begin
      m_tdata = {ob_med_val_q, ob_col_q - AddrW'(2), ob_row_q - AddrW'(2)};
      m_tlast = ob_run_end_q;
      m_tuser = 2'b01;
    end else begin
      m_tdata = {ob_px_q, ob_col_q, ob_row_q};
      m_tlast = 1'b1;
      m_tuser = {ob_last_q, 1'b0};
    end
  end

endmodule
